### rtl/tfpd_pkg.sv
// Package for the touch frame parser: frame geometry, queue sizing and shared types.
// Used by the channel interfaces and by every module of the block.
package tfpd_pkg;

    localparam int FRAME_LEN    = 7;
    localparam int CNT_W        = $clog2(FRAME_LEN);
    localparam int TRAILER_POS  = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W    = 8;

    localparam logic [7:0] SOF_RESET    = 8'h68;
    localparam logic [7:0] THRESH_RESET = 8'd2;
    localparam logic [7:0] TRAILER_BYTE = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = CFG_IDX_W'(1);

    // One position candidate taken from a frame with a good trailer.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } cand_t;

    // Push request from the front part into the queue.
    typedef struct packed {
        logic  valid;
        cand_t cand;
    } push_t;

    // Queue status and head item seen by the back part.
    typedef struct packed {
        logic  full;
        logic  not_empty;
        cand_t head;
    } queue_stat_t;

endpackage

### rtl/tfpd_if.sv
// Valid/ready channel interfaces of the touch frame parser.
// Depends on tfpd_pkg for payload widths.
interface tfpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfpd_pos_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface tfpd_cfg_if;
    import tfpd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/touch_frame_parser_deadband.sv
// Top level of the touch frame parser with deadband filtering.
// Depends on tfpd_pkg, tfpd_if, tfpd_front, tfpd_queue and tfpd_back.
//
// The block takes one received byte per item from a display serial link and reports
// touch positions. While hunting it waits for the start byte (register 0, reset 0x68);
// the start byte itself is not kept. It then collects seven frame bytes: bytes 0..1 are
// x and bytes 2..3 are y, both little-endian two's complement, and bytes 4..6 must all
// be 0xFF or the frame is dropped. A good frame yields one output item only if x or y
// differs from the last reported position by more than the threshold (register 1,
// reset 2); the last position starts at (-1, -1) and changes only when an item is
// reported. After every complete frame the block hunts again. One byte is accepted
// every clock cycle; the front part that parses bytes is held up only while the
// two-entry candidate queue is full, which needs the output side to stall. The back
// part tests one candidate per cycle while the output register is free and holds the
// result there; a report is registered in the queue and then in that output register.
// Configuration writes are always accepted; writes to other indexes are ignored.
module touch_frame_parser_deadband (
    input  logic      clk,
    input  logic      rst_n,
    tfpd_byte_if.sink   rx,
    tfpd_pos_if.source  pos,
    tfpd_cfg_if.sink    cfg
);
    import tfpd_pkg::*;

    logic [7:0]  start_byte_reg;
    logic [7:0]  move_threshold_reg;
    push_t       push;
    queue_stat_t qstat;
    logic        pop;

    // The start byte register feeds the front part and the threshold register feeds the back part.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg     <= SOF_RESET;
            move_threshold_reg <= THRESH_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_START_BYTE)
            begin
                start_byte_reg <= cfg.data;
            end
            else if (cfg.index == REG_MOVE_THRESHOLD)
            begin
                move_threshold_reg <= cfg.data;
            end
        end
    end

    // The front part parses bytes and pushes frames with a good trailer.
    tfpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .start_byte (start_byte_reg),
        .qstat      (qstat),
        .push       (push)
    );

    // The queue lets the front keep taking bytes while the output is stalled.
    tfpd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .qstat (qstat)
    );

    // The back part applies the deadband and drives the output channel.
    tfpd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .qstat          (qstat),
        .move_threshold (move_threshold_reg),
        .pop            (pop),
        .pos            (pos)
    );

endmodule

### rtl/tfpd_front.sv
// Front part: hunts for the start byte, collects a frame and checks its trailer.
// Depends on tfpd_pkg and tfpd_if; pushes good frames into tfpd_queue.
module tfpd_front (
    input  logic                clk,
    input  logic                rst_n,
    tfpd_byte_if.sink           rx,
    input  logic [7:0]          start_byte,
    input  tfpd_pkg::queue_stat_t qstat,
    output tfpd_pkg::push_t     push
);
    import tfpd_pkg::*;

    logic             in_frame_reg, in_frame_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             trailer_ok_reg, trailer_ok_next;
    logic [7:0]       b0_reg, b1_reg, b2_reg;
    // The y high byte arrives at index 3 and is held here until the frame ends.
    logic [7:0]       b3_reg;
    logic             accept;
    logic             last_byte;
    logic             byte_is_trailer;

    // The only byte that pushes is the last one, so holding off on a full queue is enough.
    assign rx.ready        = !qstat.full;
    assign accept          = rx.valid && rx.ready;
    assign last_byte       = (count_reg == CNT_W'(FRAME_LEN - 1));
    assign byte_is_trailer = (rx.rx_byte == TRAILER_BYTE);

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        count_next      = count_reg;
        trailer_ok_next = trailer_ok_reg;
        push.valid      = 1'b0;
        push.cand.x     = {b1_reg, b0_reg};
        push.cand.y     = {b3_reg, b2_reg};
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx.rx_byte == start_byte)
                begin
                    in_frame_next   = 1'b1;
                    count_next      = '0;
                    trailer_ok_next = 1'b1;
                end
            end
            else if (last_byte)
            begin
                in_frame_next = 1'b0;
                count_next    = '0;
                push.valid    = trailer_ok_reg && byte_is_trailer;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                if (count_reg >= CNT_W'(TRAILER_POS))
                begin
                    trailer_ok_next = trailer_ok_reg && byte_is_trailer;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_frame_reg)
        begin
            if (count_reg == CNT_W'(0)) b0_reg <= rx.rx_byte;
            if (count_reg == CNT_W'(1)) b1_reg <= rx.rx_byte;
            if (count_reg == CNT_W'(2)) b2_reg <= rx.rx_byte;
            if (count_reg == CNT_W'(3)) b3_reg <= rx.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            count_reg      <= '0;
            trailer_ok_reg <= 1'b1;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            count_reg      <= count_next;
            trailer_ok_reg <= trailer_ok_next;
        end
    end

endmodule

### rtl/tfpd_queue.sv
// Short queue of position candidates between the front and back parts.
// Depends on tfpd_pkg for the candidate type and depth.
module tfpd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tfpd_pkg::push_t       push,
    input  logic                  pop,
    output tfpd_pkg::queue_stat_t qstat
);
    import tfpd_pkg::*;

    cand_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push, do_pop;

    assign qstat.full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.not_empty = (cnt_reg != '0);
    assign qstat.head      = mem_reg[rd_ptr_reg];
    assign do_push         = push.valid && !qstat.full;
    assign do_pop          = pop && qstat.not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

### rtl/tfpd_back.sv
// Back part: deadband test against the last reported position and output register.
// Depends on tfpd_pkg and tfpd_if; pops candidates from tfpd_queue.
module tfpd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tfpd_pkg::queue_stat_t qstat,
    input  logic [7:0]            move_threshold,
    output logic                  pop,
    tfpd_pos_if.source            pos
);
    import tfpd_pkg::*;

    logic               out_valid_reg;
    logic signed [15:0] out_x_reg, out_y_reg;
    logic signed [15:0] last_x_reg, last_y_reg;
    logic signed [16:0] dx, dy;
    logic        [15:0] adx, ady;
    logic               moved;
    logic               out_free;

    // Differences are taken at 17 bits so they never wrap.
    assign dx  = 17'(qstat.head.x) - 17'(last_x_reg);
    assign dy  = 17'(qstat.head.y) - 17'(last_y_reg);
    assign adx = dx[16] ? 16'(-dx) : dx[15:0];
    assign ady = dy[16] ? 16'(-dy) : dy[15:0];
    assign moved = (adx > {8'd0, move_threshold}) || (ady > {8'd0, move_threshold});

    assign out_free = !out_valid_reg || pos.ready;
    assign pop      = qstat.not_empty && out_free;

    assign pos.valid = out_valid_reg;
    assign pos.pos_x = out_x_reg;
    assign pos.pos_y = out_y_reg;

    always_ff @(posedge clk)
    begin
        if (pop && moved)
        begin
            out_x_reg <= qstat.head.x;
            out_y_reg <= qstat.head.y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_x_reg    <= '1;
            last_y_reg    <= '1;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= pop && moved;
            end
            if (pop && moved)
            begin
                last_x_reg <= qstat.head.x;
                last_y_reg <= qstat.head.y;
            end
        end
    end

endmodule

### bench/tfpd_pos_checker.sv
// Position checker for the touch frame parser testbench: predicts reports from accepted bytes.
// Depends on tfpd_pkg and the channel interfaces in tfpd_if.
module tfpd_pos_checker
    import tfpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    tfpd_byte_if  rx,
    tfpd_pos_if   pos,
    tfpd_cfg_if   cfg,
    output int    fail_count,
    output int    outstanding
);

    logic [7:0]         start_byte;
    logic [7:0]         move_threshold;
    logic               hunting;
    int                 frame_idx;
    logic [7:0]         frame_data [FRAME_LEN];
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    cand_t              expected_pos [$];

    // Exact distance between two signed coordinates, no wrap.
    function automatic int distance(input logic signed [15:0] a, input logic signed [15:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    // Advances the parser state by one byte; returns 1 when a report is due.
    function automatic bit parse_byte(input logic [7:0] b, output cand_t report);
        bit good;
        int i;
        report = '0;
        if (hunting) begin
            if (b == start_byte) begin
                hunting = 1'b0;
                frame_idx = 0;
            end
            return 1'b0;
        end
        frame_data[frame_idx] = b;
        frame_idx++;
        if (frame_idx < FRAME_LEN)
            return 1'b0;
        hunting = 1'b1;
        frame_idx = 0;
        good = 1'b1;
        for (i = TRAILER_POS; i < FRAME_LEN; i++)
            if (frame_data[i] != TRAILER_BYTE)
                good = 1'b0;
        if (!good)
            return 1'b0;
        report.x = {frame_data[1], frame_data[0]};
        report.y = {frame_data[3], frame_data[2]};
        if (distance(report.x, last_x) > int'(move_threshold) ||
            distance(report.y, last_y) > int'(move_threshold))
        begin
            last_x = report.x;
            last_y = report.y;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cand_t predicted;
        cand_t got;
        cand_t want;
        if (!rst_n)
        begin
            start_byte     = SOF_RESET;
            move_threshold = THRESH_RESET;
            hunting        = 1'b1;
            frame_idx      = 0;
            last_x         = '1;
            last_y         = '1;
            expected_pos.delete();
            fail_count     = 0;
            outstanding    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_START_BYTE)
                    start_byte = cfg.data;
                else if (cfg.index == REG_MOVE_THRESHOLD)
                    move_threshold = cfg.data;
            end
            if (rx.valid && rx.ready)
            begin
                if (parse_byte(rx.rx_byte, predicted))
                    expected_pos.push_back(predicted);
            end
            if (pos.valid && pos.ready)
            begin
                got.x = pos.pos_x;
                got.y = pos.pos_y;
                if (expected_pos.size() == 0)
                begin
                    $display("%0t unexpected position: expected none, actual x %0d y %0d",
                             $time, got.x, got.y);
                    fail_count++;
                end
                else
                begin
                    want = expected_pos.pop_front();
                    if (got.x !== want.x)
                    begin
                        $display("%0t pos_x mismatch: expected %0d, actual %0d",
                                 $time, want.x, got.x);
                        fail_count++;
                    end
                    if (got.y !== want.y)
                    begin
                        $display("%0t pos_y mismatch: expected %0d, actual %0d",
                                 $time, want.y, got.y);
                        fail_count++;
                    end
                end
            end
            outstanding = expected_pos.size();
        end
    end

endmodule

### bench/tb.sv
// Testbench top for the touch frame parser: clock, reset, byte and register stimulus, verdict.
// Depends on tfpd_pkg, tfpd_if, the block itself and the tfpd_pos_checker module.
module tb;
    import tfpd_pkg::*;

    // Register indexes past the last real register; writes there must change nothing.
    localparam int FIRST_UNUSED_REG = 2;
    localparam int LAST_UNUSED_REG  = (1 << CFG_IDX_W) - 1;
    // Percentage of cycles in which either side holds off while idling is on.
    localparam int IDLE_PCT         = 27;
    // Cycles to let pass after the last expected report, so that a frame still in
    // flight inside the block, in its queue or output register, is covered.
    localparam int SETTLE_CYCLES    = 6;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;

    // Stimulus-side copy of the settings, used only to shape the byte stream.
    logic [7:0]  cur_start;
    logic [7:0]  cur_thresh;
    bit          rx_gaps;
    bit          out_stalls;
    // Coordinates of the last good frame sent, so that moves near the deadband
    // edge can be aimed at.
    logic [15:0] near_x;
    logic [15:0] near_y;
    logic [7:0]  frame_buf [FRAME_LEN];

    tfpd_byte_if rx_if ();
    tfpd_pos_if  pos_if ();
    tfpd_cfg_if  cfg_if ();

    touch_frame_parser_deadband u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .pos   (pos_if),
        .cfg   (cfg_if)
    );

    tfpd_pos_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx_if),
        .pos         (pos_if),
        .cfg         (cfg_if),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // The report side stalls at random while stalls are enabled and is always
    // ready otherwise.
    always @(posedge clk)
    begin
        pos_if.ready <= out_stalls ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    // Offers one byte and returns at the edge where it is accepted. Valid is left
    // high, so back-to-back items never lower and raise it in the same step; it
    // only drops during a random gap or when release_rx is called.
    task automatic send_byte(input logic [7:0] b);
        if (rx_gaps)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                rx_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
    endtask

    task automatic release_rx();
        rx_if.valid <= 1'b0;
    endtask

    // Register writes follow the same pattern as bytes: valid stays high across a
    // group of writes and release_cfg drops it afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx == REG_START_BYTE)
            cur_start = value;
        else if (idx == REG_MOVE_THRESHOLD)
            cur_thresh = value;
    endtask

    task automatic release_cfg();
        cfg_if.valid <= 1'b0;
    endtask

    // Holds the sender off until every predicted report has come out. The
    // outstanding count is sampled on the falling edge, away from the edge at
    // which the checker updates it. A frame that ends in no report may still be
    // inside the block, so a few more cycles pass before anything else changes.
    task automatic drain();
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Lays out a frame with the given position and a good trailer.
    task automatic fill_frame(input logic [15:0] x, input logic [15:0] y);
        int i;
        frame_buf[0] = x[7:0];
        frame_buf[1] = x[15:8];
        frame_buf[2] = y[7:0];
        frame_buf[3] = y[15:8];
        for (i = TRAILER_POS; i < FRAME_LEN; i++)
            frame_buf[i] = TRAILER_BYTE;
    endtask

    // Sends the start byte followed by the first len bytes of the frame buffer.
    // A short len makes a truncated frame, so the next start byte lands as data.
    task automatic send_frame(input int len);
        int i;
        send_byte(cur_start);
        for (i = 0; i < len; i++)
            send_byte(frame_buf[i]);
    endtask

    // A coordinate that is either an extreme, a small move around the previous
    // one that straddles the deadband edge, or anything at all.
    function automatic logic [15:0] pick_coord(input logic [15:0] near);
        int r;
        int span;
        int d;
        r    = $urandom_range(0, 9);
        span = int'(cur_thresh) + 2;
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (r < 5)
        begin
            d = int'($urandom_range(0, 2 * span)) - span;
            return near + 16'(d);
        end
        return 16'($urandom);
    endfunction

    // Random traffic until about n_bytes frame bytes have gone in. Most of it is
    // well-formed frames with random positions; the rest is stray bytes while
    // hunting, frames with a broken trailer, frames that carry the start byte as
    // data and truncated frames that push the parser out of step.
    task automatic run_traffic(input int n_bytes);
        int          sent;
        int          kind;
        int          n;
        logic [7:0]  b;
        logic [15:0] x;
        logic [15:0] y;
        sent = 0;
        while (sent < n_bytes)
        begin
            kind = $urandom_range(0, 99);
            x    = pick_coord(near_x);
            y    = pick_coord(near_y);
            fill_frame(x, y);
            if (kind < 10)
            begin
                // Noise while hunting; the start byte is kept out of it.
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    b = 8'($urandom);
                    if (b == cur_start)
                        b = ~b;
                    send_byte(b);
                end
            end
            else if (kind < 25)
            begin
                n = $urandom_range(TRAILER_POS, FRAME_LEN - 1);
                frame_buf[n] = frame_buf[n] ^ 8'(1 << $urandom_range(0, 7));
                send_frame(FRAME_LEN);
                sent += FRAME_LEN + 1;
            end
            else if (kind < 35)
            begin
                frame_buf[$urandom_range(0, TRAILER_POS - 1)] = cur_start;
                send_frame(FRAME_LEN);
                sent += FRAME_LEN + 1;
            end
            else if (kind < 42)
            begin
                n = $urandom_range(1, FRAME_LEN - 1);
                send_frame(n);
                sent += n + 1;
            end
            else
            begin
                send_frame(FRAME_LEN);
                sent += FRAME_LEN + 1;
                near_x = x;
                near_y = y;
            end
        end
    endtask

    // Moves to a new setting with the block idle: stop the bytes, wait for every
    // report, write both registers plus one index that does not exist, and pick
    // the idling for the next stretch of traffic.
    task automatic new_setting(input logic [7:0] sb, input logic [7:0] th,
                               input bit gaps, input bit stalls);
        release_rx();
        drain();
        write_reg(REG_START_BYTE, sb);
        write_reg(REG_MOVE_THRESHOLD, th);
        write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)),
                  8'($urandom));
        release_cfg();
        rx_gaps    = gaps;
        out_stalls = stalls;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;
        pos_if.ready   = 1'b0;
        cur_start      = SOF_RESET;
        cur_thresh     = THRESH_RESET;
        rx_gaps        = 1'b1;
        out_stalls     = 1'b1;
        near_x         = '1;
        near_y         = '1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the reset settings. Bytes other than the start byte
        // are ignored while hunting, the trailer value among them.
        send_byte(8'h00);
        send_byte(TRAILER_BYTE);
        // The origin is only one step from the reset position (-1, -1), which is
        // inside the deadband, so nothing is reported.
        fill_frame(16'h0000, 16'h0000);
        send_frame(FRAME_LEN);
        // Largest positive x and most negative y: reported.
        fill_frame(16'h7FFF, 16'h8000);
        send_frame(FRAME_LEN);
        // Swapped extremes, a full-scale move on both axes, but the last trailer
        // byte is off by one bit, so the frame is dropped.
        fill_frame(16'h8000, 16'h7FFF);
        frame_buf[FRAME_LEN - 1] = 8'hFE;
        send_frame(FRAME_LEN);
        near_x = 16'h7FFF;
        near_y = 16'h8000;

        // Random part, one stretch per setting. The third stretch runs with no
        // idling on either side; each change of setting also makes the sender
        // wait until every report has come out.
        run_traffic(100);
        new_setting(8'h00, 8'd0, 1'b1, 1'b1);
        run_traffic(100);
        new_setting(8'hFF, 8'hFF, 1'b0, 1'b0);
        run_traffic(100);
        new_setting(8'($urandom), 8'($urandom_range(0, 15)), 1'b1, 1'b1);
        run_traffic(100);
        new_setting(SOF_RESET, 8'd1, 1'b1, 1'b0);
        run_traffic(100);

        release_rx();
        drain();
        if (fail_count == 0 && outstanding == 0)
            $display("touch_frame_parser_deadband regression: pass");
        else
            $display("touch_frame_parser_deadband regression: fail");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("touch_frame_parser_deadband regression: fail");
        $finish;
    end

endmodule
